FILE: hw/rtl/swev_pkg.sv
// ----------------------------------------------------------------------------
// swev_pkg
// Types and constants shared by the spill window event veto block.
// ----------------------------------------------------------------------------
package swev_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_MARKER = 2'd1;
  localparam logic [1:0] ACT_CLOSE  = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NO_SPILL   = 2'd0;
  localparam logic [1:0] VERDICT_CLEAR      = 2'd1;
  localparam logic [1:0] VERDICT_VETOED     = 2'd2;
  localparam logic [1:0] VERDICT_NO_MARKERS = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BUFFER_BEFORE = 1'b0;
  localparam logic CFG_BUFFER_AFTER  = 1'b1;

  // One 50 us microblock and one 10 us spill, in 1/64 us ticks.
  localparam logic [63:0] MICROBLOCK_TICKS = 64'd3200;
  localparam logic [63:0] SPILL_LEN_TICKS  = 64'd640;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] time_value;
  } item_t;

  typedef struct packed {
    logic       keep_event;
    logic [1:0] verdict;
    logic       spill_table_overflow;
  } result_t;

  // Widened bounds of the open event.
  typedef struct packed {
    logic        marker_seen;
    logic [63:0] start_buf;
    logic [63:0] end_buf;
  } evt_bounds_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } swev_state_t;

endpackage

FILE: hw/rtl/swev_spill_mem.sv
// ----------------------------------------------------------------------------
// swev_spill_mem
// Spill timestamp table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swev_spill_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/swev_event_track.sv
// ----------------------------------------------------------------------------
// swev_event_track
// Tracks the minimum and maximum marker of the open event and forms the
// widened event bounds.
// ----------------------------------------------------------------------------
module swev_event_track
  import swev_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mark_en,
  input  logic [63:0] mark_time,
  input  logic        clear,
  input  logic [31:0] buffer_before_ticks,
  input  logic [31:0] buffer_after_ticks,
  output evt_bounds_t bounds
);

  logic [63:0] min_time;
  logic [63:0] max_time;
  logic        marker_seen;

  // Marker extremes; a close returns them to their reset values.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      min_time    <= '1;
      max_time    <= '0;
      marker_seen <= 1'b0;
    end else if (mark_en) begin
      if (mark_time < min_time) begin
        min_time <= mark_time;
      end
      if (mark_time > max_time) begin
        max_time <= mark_time;
      end
      marker_seen <= 1'b1;
    end
  end

  // Widened bounds, both wrapping modulo 2^64.
  always_comb begin
    bounds.marker_seen = marker_seen;
    bounds.start_buf   = min_time - {32'd0, buffer_before_ticks};
    bounds.end_buf     = max_time + MICROBLOCK_TICKS + {32'd0, buffer_after_ticks};
  end

endmodule

FILE: hw/rtl/spill_window_event_veto.sv
// Load and marker items: one per cycle while the block is idle.
// Close item: the table scan reads one entry per cycle through the single
// memory read port, and inputs stall meanwhile.
// Throughput: one load or marker per cycle while idle; closes are limited by the scan.
// Reset (rst, synchronous): empties the table, clears the overflow flag,
// the event and the buffer registers; the table needs no clearing pass.
// ----------------------------------------------------------------------------
// spill_window_event_veto
// Vetoes events that lie near a beam spill, using a table of spill times.
// ----------------------------------------------------------------------------
module spill_window_event_veto
  import swev_pkg::*;
#(
  parameter int MAX_SPILLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  localparam int AW = (MAX_SPILLS > 1) ? $clog2(MAX_SPILLS) : 1;
  localparam int CW = $clog2(MAX_SPILLS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SPILLS);

  swev_state_t state, state_next;

  logic [31:0]   buffer_before_ticks;
  logic [31:0]   buffer_after_ticks;
  logic [CW-1:0] spill_count;
  logic          overflow_flag;
  logic [CW-1:0] rd_idx;
  logic          rd_pend;
  logic          found;
  logic [63:0]   latest;
  logic [63:0]   start_buf;
  logic [63:0]   end_buf;

  logic          item_xfer;
  logic          is_load, is_marker, is_close;
  logic          table_full;
  logic          rd_en;
  logic          scan_done;
  logic [63:0]   rd_data;
  logic [63:0]   latest_end;
  logic          result_set;
  result_t       result_next;
  evt_bounds_t   bounds;

  // Input decode.
  assign item_xfer  = item_valid && !item_stall;
  assign is_load    = item_xfer && (item.action == ACT_LOAD);
  assign is_marker  = item_xfer && (item.action == ACT_MARKER);
  assign is_close   = item_xfer && (item.action == ACT_CLOSE);
  assign table_full = (spill_count == FULL_COUNT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_before_ticks <= '0;
      buffer_after_ticks  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_BUFFER_BEFORE: buffer_before_ticks <= cfg_data;
        CFG_BUFFER_AFTER:  buffer_after_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event bounds tracking.
  swev_event_track u_track (
    .clk                 (clk),
    .rst                 (rst),
    .mark_en             (is_marker),
    .mark_time           (item.time_value),
    .clear               (is_close),
    .buffer_before_ticks (buffer_before_ticks),
    .buffer_after_ticks  (buffer_after_ticks),
    .bounds              (bounds)
  );

  // Spill table.
  swev_spill_mem #(
    .DEPTH (MAX_SPILLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (is_load && !table_full),
    .wr_addr (spill_count[AW-1:0]),
    .wr_data (item.time_value),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Fill count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (is_load) begin
      if (table_full) begin
        overflow_flag <= 1'b1;
      end else begin
        spill_count <= spill_count + 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_close && bounds.marker_seen) begin
          state_next = (spill_count == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs: inputs stall during the scan and decision, and a close waits while a result is still held.
  always_comb begin
    item_stall = 1'b1;
    rd_en      = 1'b0;
    scan_done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_stall = result_valid && (item.action == ACT_CLOSE);
      end
      ST_SCAN: begin
        rd_en     = (rd_idx < spill_count);
        scan_done = !rd_en && !rd_pend;
      end
      ST_DECIDE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan: read pointer, read pipeline flag and the running latest spill.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else if (is_close) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend && (rd_data <= end_buf) && (!found || (rd_data > latest))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_close) begin
      start_buf <= bounds.start_buf;
      end_buf   <= bounds.end_buf;
    end
    if (rd_pend && (rd_data <= end_buf) && (!found || (rd_data > latest))) begin
      latest <= rd_data;
    end
  end

  // Verdict.
  assign latest_end = latest + SPILL_LEN_TICKS;

  always_comb begin
    result_set  = 1'b0;
    result_next = result;
    result_next.spill_table_overflow = overflow_flag;
    if (state == ST_DECIDE) begin
      result_set = 1'b1;
      if (!found) begin
        result_next.keep_event = 1'b1;
        result_next.verdict    = VERDICT_NO_SPILL;
      end else if (latest_end <= start_buf) begin
        result_next.keep_event = 1'b1;
        result_next.verdict    = VERDICT_CLEAR;
      end else begin
        result_next.keep_event = 1'b0;
        result_next.verdict    = VERDICT_VETOED;
      end
    end else if (is_close && !bounds.marker_seen) begin
      result_set             = 1'b1;
      result_next.keep_event = 1'b0;
      result_next.verdict    = VERDICT_NO_MARKERS;
    end
  end

  // Output register, held until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_set) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_set) begin
      result <= result_next;
    end
  end

endmodule
